// ===== rtl/moving_average_threshold_monitor_defines.svh =====
// Assertion macros shared by the moving average monitor modules.
// Each use expects a clock named clk and a synchronous reset named rst in scope.
`ifndef MOVING_AVERAGE_THRESHOLD_MONITOR_DEFINES_SVH
`define MOVING_AVERAGE_THRESHOLD_MONITOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MAT_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MAT_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mat_pkg.sv =====
// Package for the moving average threshold monitor: payload types, command and
// status structs, register indexes and fixed widths. No dependencies.
`timescale 1ns / 1ps

package mat_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int LEN_CFG_W      = 9;
  localparam int DIV_W          = 48;
  localparam int CNT_W          = 32;
  localparam int CFG_IDX_W      = 1;
  localparam int DEF_MAX_WINDOW = 256;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b1;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] window_average;
    logic                       above_threshold;
    logic signed [SAMPLE_W-1:0] running_average;
    logic signed [SAMPLE_W-1:0] oldest_quarter_average;
    logic signed [SAMPLE_W-1:0] newest_quarter_average;
  } result_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR_INIT,
    OP_CLR_STEP,
    OP_ACCEPT,
    OP_WRITE,
    OP_WALK_INIT,
    OP_WALK_STEP,
    OP_WALK_STORE,
    OP_DIV_START,
    OP_RESULT
  } op_t;

  typedef enum logic [1:0] {
    SEL_WIN,
    SEL_OLD,
    SEL_NEW,
    SEL_RUN
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic walk_last;
    logic act_clear;
    logic q_zero;
    logic count_zero;
    logic div_busy;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/mat_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mat_div.sv =====
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating.
// Depends on mat_pkg for the operand widths.
`timescale 1ns / 1ps

module mat_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [mat_pkg::DIV_W-1:0]  dividend,
  input  logic        [mat_pkg::CNT_W-1:0]  divisor,
  output logic                              busy,
  output logic                              done,
  output logic signed [mat_pkg::SAMPLE_W-1:0] quotient
);
  import mat_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [CNT_W-1:0]  dsr;
  logic              neg;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    trial;
  logic [DIV_W-1:0]  quo_signed;

  assign shifted = {rem, quo[DIV_W-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_W);
        rem   <= '0;
        dsr   <= divisor;
        neg   <= dividend[DIV_W-1];
        quo   <= dividend[DIV_W-1] ? DIV_W'(-dividend) : dividend;
      end else if (busy) begin
        if (shifted >= {1'b0, dsr}) begin
          rem <= trial[CNT_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= shifted[CNT_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo_signed = neg ? (~quo + DIV_W'(1)) : quo;
  assign quotient   = quo_signed[SAMPLE_W-1:0];

endmodule

// ===== rtl/mat_datapath.sv =====
// Datapath of the moving average monitor: configuration registers, sample RAM,
// slot walks, totals, shared divider and result register. Depends on mat_pkg.
`timescale 1ns / 1ps
`include "moving_average_threshold_monitor_defines.svh"

module mat_datapath #(
  parameter int MAX_WINDOW = mat_pkg::DEF_MAX_WINDOW
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mat_pkg::cmd_t                     cmd,
  output mat_pkg::status_t                  st,
  input  mat_pkg::item_t                    item,
  input  logic                              cfg_we,
  input  logic [mat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mat_pkg::SAMPLE_W-1:0]      cfg_data,
  input  logic                              result_stall,
  output logic                              result_valid,
  output mat_pkg::result_t                  result
);
  import mat_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int PROD_W = SAMPLE_W + LEN_W + 1;
  localparam int CMP_W  = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_WINDOW);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(MAX_WINDOW - 1);

  logic signed [SAMPLE_W-1:0] threshold;
  logic [LEN_CFG_W-1:0]       window_length;
  logic [ADDR_W-1:0]          wpos;
  logic signed [DIV_W-1:0]    total_sum;
  logic [CNT_W-1:0]           total_count;
  logic [ADDR_W-1:0]          clr_ptr;
  logic [ADDR_W-1:0]          walk_ptr;
  logic [LEN_W-1:0]           walk_cnt;
  logic                       acc_v;
  logic signed [SUM_W-1:0]    acc;
  logic signed [SUM_W-1:0]    win_sum;
  logic signed [SUM_W-1:0]    old_sum;
  logic signed [SUM_W-1:0]    new_sum;
  logic signed [PROD_W-1:0]   prod;
  item_t                      item_reg;
  logic signed [SAMPLE_W-1:0] q_win, q_run, q_old, q_new;

  logic [LEN_W-1:0]           len;
  logic [LEN_W-1:0]           qlen;
  logic [ADDR_W-1:0]          len_m1;
  logic [ADDR_W-1:0]          pos_base;
  logic [LEN_W-1:0]           pos_inc;
  logic [ADDR_W-1:0]          pos_next;
  logic [ADDR_W-1:0]          pos_prev;
  logic [LEN_W-1:0]           walk_inc;
  logic [ADDR_W-1:0]          walk_fwd;
  logic [ADDR_W-1:0]          walk_bwd;

  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [SAMPLE_W-1:0]        ram_wdata;
  logic [SAMPLE_W-1:0]        ram_rdata;

  logic                       div_start;
  logic signed [DIV_W-1:0]    div_dividend;
  logic [CNT_W-1:0]           div_divisor;
  logic                       div_busy;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] div_quotient;

  // Effective window length, clamped to one slot at least and the store size at most.
  always_comb begin
    if (window_length == '0) begin
      len = LEN_W'(1);
    end else if (CMP_W'(window_length) > CMP_W'(MAX_WINDOW)) begin
      len = LEN_MAX;
    end else begin
      len = LEN_W'(window_length);
    end
  end

  assign qlen     = len >> 2;
  assign len_m1   = ADDR_W'(len - LEN_W'(1));
  assign pos_base = (LEN_W'(wpos) >= len) ? '0 : wpos;
  assign pos_inc  = LEN_W'(pos_base) + LEN_W'(1);
  assign pos_next = (pos_inc >= len) ? '0 : ADDR_W'(pos_inc);
  assign pos_prev = (pos_base == '0) ? len_m1 : pos_base - ADDR_W'(1);
  assign walk_inc = LEN_W'(walk_ptr) + LEN_W'(1);
  assign walk_fwd = (walk_inc >= len) ? '0 : ADDR_W'(walk_inc);
  assign walk_bwd = (walk_ptr == '0) ? len_m1 : walk_ptr - ADDR_W'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_ptr;
    ram_wdata = '0;
    case (cmd.op)
      OP_CLR_STEP: begin
        ram_we = 1'b1;
      end
      OP_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_base;
        ram_wdata = item_reg.sample;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  mat_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (walk_ptr),
    .rdata (ram_rdata)
  );

  always_comb begin
    case (cmd.sel)
      SEL_WIN: begin
        div_dividend = DIV_W'(win_sum);
        div_divisor  = CNT_W'(len);
      end
      SEL_OLD: begin
        div_dividend = DIV_W'(old_sum);
        div_divisor  = CNT_W'(qlen);
      end
      SEL_NEW: begin
        div_dividend = DIV_W'(new_sum);
        div_divisor  = CNT_W'(qlen);
      end
      default: begin
        div_dividend = total_sum;
        div_divisor  = total_count;
      end
    endcase
  end

  assign div_start = (cmd.op == OP_DIV_START);

  mat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= '0;
      window_length <= LEN_CFG_W'(256);
      wpos          <= '0;
      total_sum     <= '0;
      total_count   <= '0;
      clr_ptr       <= '0;
      walk_cnt      <= '0;
      acc_v         <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THRESHOLD:     threshold     <= cfg_data;
          CFG_WINDOW_LENGTH: window_length <= cfg_data[LEN_CFG_W-1:0];
          default:           threshold     <= threshold;
        endcase
      end

      acc_v <= (cmd.op == OP_WALK_STEP);
      if (acc_v) begin
        acc <= acc + SUM_W'($signed(ram_rdata));
      end

      if (div_done) begin
        case (cmd.sel)
          SEL_WIN: q_win <= div_quotient;
          SEL_OLD: q_old <= div_quotient;
          SEL_NEW: q_new <= div_quotient;
          default: q_run <= div_quotient;
        endcase
      end

      if (result_valid && !result_stall && cmd.op != OP_RESULT) begin
        result_valid <= 1'b0;
      end

      case (cmd.op)
        OP_CLR_INIT: begin
          clr_ptr <= '0;
        end
        OP_CLR_STEP: begin
          clr_ptr <= clr_ptr + ADDR_W'(1);
        end
        OP_ACCEPT: begin
          item_reg <= item;
          prod     <= PROD_W'(threshold) * $signed({1'b0, len});
          q_run    <= '0;
          q_old    <= '0;
          q_new    <= '0;
        end
        OP_WRITE: begin
          wpos <= pos_next;
          if (total_count != '1) begin
            total_sum   <= total_sum + DIV_W'($signed(item_reg.sample));
            total_count <= total_count + CNT_W'(1);
          end
        end
        OP_WALK_INIT: begin
          acc <= '0;
          case (cmd.sel)
            SEL_WIN: begin
              walk_ptr <= '0;
              walk_cnt <= len;
            end
            SEL_OLD: begin
              walk_ptr <= pos_base;
              walk_cnt <= qlen;
            end
            default: begin
              walk_ptr <= pos_prev;
              walk_cnt <= qlen;
            end
          endcase
        end
        OP_WALK_STEP: begin
          walk_cnt <= walk_cnt - LEN_W'(1);
          walk_ptr <= (cmd.sel == SEL_NEW) ? walk_bwd : walk_fwd;
        end
        OP_WALK_STORE: begin
          case (cmd.sel)
            SEL_WIN: win_sum <= acc;
            SEL_OLD: old_sum <= acc;
            default: new_sum <= acc;
          endcase
        end
        OP_RESULT: begin
          result_valid                  <= 1'b1;
          result.window_average         <= q_win;
          result.above_threshold        <= (PROD_W'(win_sum) > prod);
          result.running_average        <= q_run;
          result.oldest_quarter_average <= q_old;
          result.newest_quarter_average <= q_new;
        end
        default: begin
          clr_ptr <= clr_ptr;
        end
      endcase
    end
  end

  assign st.clr_last   = (clr_ptr == LAST_SLOT);
  assign st.walk_last  = (walk_cnt == LEN_W'(1));
  assign st.act_clear  = item_reg.action;
  assign st.q_zero     = (qlen == '0);
  assign st.count_zero = (total_count == '0);
  assign st.div_busy   = div_busy;
  assign st.div_done   = div_done;
  assign st.out_free   = !result_valid || !result_stall;

  `MAT_CHECK(a_div_start_idle, cmd.op == OP_DIV_START, !div_busy, "divider started while busy")
  `MAT_CHECK_NEXT(a_div_done_frees, div_done, !div_busy, "divider busy after done")
  `MAT_CHECK(a_walk_in_range, cmd.op == OP_WALK_STEP, walk_cnt != '0, "walk step past its end")
  `MAT_CHECK_NEXT(a_count_saturates, total_count == '1, total_count == '1, "count left saturation")

endmodule

// ===== rtl/mat_ctrl.sv =====
// Controller state machine of the moving average monitor: sequences clearing,
// slot walks, divisions and the result. Depends on mat_pkg.
`timescale 1ns / 1ps
`include "moving_average_threshold_monitor_defines.svh"

module mat_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  mat_pkg::status_t st,
  output mat_pkg::cmd_t    cmd
);
  import mat_pkg::*;

  typedef enum logic [3:0] {
    S_CLR_INIT,
    S_CLR,
    S_IDLE,
    S_WRITE,
    S_WALK_INIT,
    S_WALK,
    S_DRAIN,
    S_STORE,
    S_DIV_START,
    S_DIV_WAIT,
    S_RESULT
  } state_t;

  state_t state, state_next;
  sel_t   sel, sel_next;
  logic   in_item, in_item_next;

  always_comb begin
    state_next   = state;
    sel_next     = sel;
    in_item_next = in_item;
    cmd.op       = OP_NONE;
    cmd.sel      = sel;
    unique case (state)
      S_CLR_INIT: begin
        cmd.op     = OP_CLR_INIT;
        state_next = S_CLR;
      end
      S_CLR: begin
        cmd.op = OP_CLR_STEP;
        if (st.clr_last) begin
          state_next = in_item ? S_WALK_INIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.op       = OP_ACCEPT;
          in_item_next = 1'b1;
          state_next   = S_WRITE;
        end
      end
      S_WRITE: begin
        sel_next = SEL_WIN;
        if (st.act_clear) begin
          state_next = S_CLR_INIT;
        end else begin
          cmd.op     = OP_WRITE;
          state_next = S_WALK_INIT;
        end
      end
      S_WALK_INIT: begin
        cmd.op     = OP_WALK_INIT;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.op = OP_WALK_STEP;
        if (st.walk_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_STORE;
      end
      S_STORE: begin
        cmd.op = OP_WALK_STORE;
        case (sel)
          SEL_WIN: begin
            if (st.q_zero) begin
              state_next = S_DIV_START;
            end else begin
              sel_next   = SEL_OLD;
              state_next = S_WALK_INIT;
            end
          end
          SEL_OLD: begin
            sel_next   = SEL_NEW;
            state_next = S_WALK_INIT;
          end
          default: begin
            sel_next   = SEL_WIN;
            state_next = S_DIV_START;
          end
        endcase
      end
      S_DIV_START: begin
        cmd.op     = OP_DIV_START;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (st.div_done) begin
          case (sel)
            SEL_WIN: begin
              if (!st.q_zero) begin
                sel_next   = SEL_OLD;
                state_next = S_DIV_START;
              end else if (!st.count_zero) begin
                sel_next   = SEL_RUN;
                state_next = S_DIV_START;
              end else begin
                state_next = S_RESULT;
              end
            end
            SEL_OLD: begin
              sel_next   = SEL_NEW;
              state_next = S_DIV_START;
            end
            SEL_NEW: begin
              if (st.count_zero) begin
                state_next = S_RESULT;
              end else begin
                sel_next   = SEL_RUN;
                state_next = S_DIV_START;
              end
            end
            default: begin
              state_next = S_RESULT;
            end
          endcase
        end
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.op       = OP_RESULT;
          in_item_next = 1'b0;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR_INIT;
      sel     <= SEL_WIN;
      in_item <= 1'b0;
    end else begin
      state   <= state_next;
      sel     <= sel_next;
      in_item <= in_item_next;
    end
  end

  assign item_stall = (state != S_IDLE);

  `MAT_CHECK(a_done_in_wait, st.div_done, state == S_DIV_WAIT, "division ended outside wait")
  `MAT_CHECK(a_result_free, cmd.op == OP_RESULT, st.out_free, "result issued onto a held beat")
  `MAT_CHECK_NEXT(a_accept_writes, state == S_IDLE && item_valid, state == S_WRITE,
                  "accepted beat not processed")

endmodule

// ===== rtl/moving_average_threshold_monitor.sv =====
// Top level of the moving average threshold monitor: controller and datapath.
// Depends on mat_pkg, mat_ctrl and mat_datapath.
`timescale 1ns / 1ps

// For an effective window length L, each input beat either writes a signed
// sample into a ring of L slots in a store of MAX_WINDOW slots or clears every
// slot, and gives one result beat carrying the window average, the
// above-threshold flag, the all-time average and the oldest and newest quarter
// averages. Items are handled one at a time. With quarter Q = floor(L/4), a
// sample item walks L + 2Q slots in three walks over the single read port of
// the sample RAM (one walk when Q is zero), plus up to four divisions on the
// shared serial divider: the window, both quarters and the all-time average.
// A clear item adds a sweep over every slot of the RAM. After reset the same
// clearing pass runs, during which item_stall is high; configuration writes
// are taken at any time but should only be made while the block is idle. A
// finished result sits in an output register, so a stalled result beat holds
// the next item off only at its very end.
module moving_average_threshold_monitor #(
  parameter int MAX_WINDOW = mat_pkg::DEF_MAX_WINDOW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  mat_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output mat_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mat_pkg::SAMPLE_W-1:0]  cfg_data
);
  import mat_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Registers are always writable; the contract keeps writes to idle periods.
  assign cfg_ready = 1'b1;

  // The controller only sequences; all storage and arithmetic live in the datapath.
  mat_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  mat_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .item         (item),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
